// File: src/dit_pkg.sv
// ----------------------------------------------------------------------------
// dit_pkg
// Shared constants and controller/datapath interface types for the
// constant interning table.
// ----------------------------------------------------------------------------
package dit_pkg;

    localparam int DEF_DEPTH       = 256;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int VALUE_IN_W      = 32;
    localparam int INDEX_OUT_W     = 8;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the value and restart the scan
        logic clear;  // empty the table and zero the result
        logic scan;   // issue the next read and compare
        logic hit;    // record the matching index as the result
        logic miss;   // append the value, or flag a full table
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;  // the entry under compare equals the value
        logic done;   // every stored entry has been compared
    } t_dp_stat;

endpackage

// File: src/dit_ctrl.sv
// ----------------------------------------------------------------------------
// dit_ctrl
// Controller for the interning table: accepts an item, steps the scan and
// presents one result strobe.
// ----------------------------------------------------------------------------
module dit_ctrl
    import dit_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_action,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_valid
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (i_action == ACT_CLEAR) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_DONE;
                end else if (i_stat.done) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

// File: src/dit_dp.sv
// ----------------------------------------------------------------------------
// dit_dp
// Datapath for the interning table: value store, entry count, scan pointer,
// comparator and result registers.
// ----------------------------------------------------------------------------
module dit_dp
    import dit_pkg::*;
#(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [VALUE_IN_W-1:0]  i_value,
    output t_dp_stat               o_stat,
    output logic [INDEX_OUT_W-1:0] o_entry_index,
    output logic                   o_already_present,
    output logic                   o_table_full
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_rd_idx;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic                   r_cmp_vld;
    logic [INDEX_OUT_W-1:0] r_res_idx;
    logic                   r_res_present;
    logic                   r_res_oom;

    logic rd_en;
    logic wr_en;
    logic full;

    assign full  = (r_count == FULL_COUNT);
    assign rd_en = i_cmd.scan && (r_rd_idx < r_count);
    assign wr_en = i_cmd.miss && !full;

    assign o_stat.match = r_cmp_vld && (r_rd_data == r_value);
    assign o_stat.done  = (r_rd_idx == r_count);

    // Store: one read and one write port, read data registered.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[IDX_W-1:0]];
        end
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= r_value;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= VALUE_WIDTH'(i_value);
        end
        if (rd_en) begin
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (i_cmd.clear) begin
            r_res_idx     <= '0;
            r_res_present <= 1'b0;
            r_res_oom     <= 1'b0;
        end else if (i_cmd.hit) begin
            r_res_idx     <= INDEX_OUT_W'(r_cmp_idx);
            r_res_present <= 1'b1;
            r_res_oom     <= 1'b0;
        end else if (i_cmd.miss) begin
            r_res_idx     <= full ? '0 : INDEX_OUT_W'(r_count);
            r_res_present <= 1'b0;
            r_res_oom     <= full;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= rd_en;
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                end
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    assign o_entry_index     = r_res_idx;
    assign o_already_present = r_res_present;
    assign o_table_full      = r_res_oom;

endmodule

// File: src/dedup_intern_table.sv
// ----------------------------------------------------------------------------
// dedup_intern_table
// Interning table for constant value words with a fixed number of entries.
//
// An item is accepted on a rising edge with start high and busy low. i_action
// selects insert or clear; i_value is the word to intern, masked to
// VALUE_WIDTH bits. Busy stays high until the result has been shown.
// Each item gives one result, held on the o_ ports for one cycle while
// o_valid is high. The receiver cannot stall, so no result is ever held back.
// A clear item gives its all-zero result in the cycle after acceptance.
// An insert reads the store one entry per cycle through its single read port:
// a hit at index k shows its result once entry k has been compared, a miss with
// n entries stored once all n have been compared. The next item can be
// taken in the cycle after the strobe.
// A miss appends the value unless the table is full, in which case the result
// carries o_table_full with index zero and the table is left unchanged.
// Reset empties the table at once; the store itself is not cleared, since
// only entries below the entry count are ever read.
// ----------------------------------------------------------------------------
module dedup_intern_table
    import dit_pkg::*;
#(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_action,
    input  logic [VALUE_IN_W-1:0]  i_value,
    output logic                   o_valid,
    output logic [INDEX_OUT_W-1:0] o_entry_index,
    output logic                   o_already_present,
    output logic                   o_table_full
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dit_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    dit_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_value           (i_value),
        .o_stat            (stat),
        .o_entry_index     (o_entry_index),
        .o_already_present (o_already_present),
        .o_table_full      (o_table_full)
    );

    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted item");

    // The result strobe only appears while an item is in flight.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside of an item");

    // A full-table result reports neither a hit nor an index.
    a_oom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> !o_already_present && (o_entry_index == '0))
        else $error("full-table result with hit or nonzero index");

    // Each strobe lasts one cycle.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

// File: tb/intern_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intern_checker
// Watches the item and result channels of the interning table. It keeps a
// private copy of the stored words and the entry count, works out the result
// of every accepted item, and compares each strobed result field by field
// with the oldest outstanding one.
// ----------------------------------------------------------------------------
module intern_checker
    import dit_pkg::*;
#(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic                   i_action,
    input  logic [VALUE_IN_W-1:0]  i_value,
    input  logic                   o_valid,
    input  logic [INDEX_OUT_W-1:0] o_entry_index,
    input  logic                   o_already_present,
    input  logic                   o_table_full,
    input  logic                   i_drain_done,
    output int                     o_err_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [INDEX_OUT_W-1:0] entry_index;
        logic                   already_present;
        logic                   table_full;
    } intern_result_t;

    localparam logic [VALUE_IN_W-1:0] VALUE_MASK = (VALUE_WIDTH >= VALUE_IN_W) ? '1 :
        VALUE_IN_W'((64'd1 << VALUE_WIDTH) - 64'd1);

    logic [VALUE_IN_W-1:0] interned_words [DEPTH];
    int unsigned           interned_count = 0;
    intern_result_t        expected_results [$];

    int err_count     = 0;
    int results_seen  = 0;
    int n_appends     = 0;
    int n_found       = 0;
    int n_full        = 0;
    int n_clears      = 0;
    int peak_count    = 0;
    bit drain_checked = 1'b0;

    assign o_err_count = err_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        err_count++;
    endtask

    // Applies one item to the shadow table and returns the result it must give.
    function automatic intern_result_t predict_intern(input logic act,
                                                      input logic [VALUE_IN_W-1:0] raw);
        intern_result_t        r;
        logic [VALUE_IN_W-1:0] word;
        int unsigned           idx;
        bit                    found;
        r     = '0;
        word  = raw & VALUE_MASK;
        found = 1'b0;
        if (act == ACT_CLEAR) begin
            interned_count = 0;
            n_clears++;
            return r;
        end
        for (idx = 0; idx < interned_count; idx++) begin
            if (!found && interned_words[idx] == word) begin
                found             = 1'b1;
                r.entry_index     = INDEX_OUT_W'(idx);
                r.already_present = 1'b1;
            end
        end
        if (found) begin
            n_found++;
        end else if (interned_count >= DEPTH) begin
            r.table_full = 1'b1;
            n_full++;
        end else begin
            interned_words[interned_count] = word;
            r.entry_index = INDEX_OUT_W'(interned_count);
            interned_count++;
            n_appends++;
            if (interned_count > peak_count) peak_count = interned_count;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        intern_result_t want;
        if (!i_rst_n) begin
            interned_count = 0;
        end else begin
            // A result can never belong to an item accepted at this same edge.
            if (o_valid) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no item outstanding (index %0d)",
                                              results_seen, o_entry_index));
                end else begin
                    want = expected_results.pop_front();
                    if (o_entry_index !== want.entry_index)
                        report_mismatch($sformatf("result %0d: entry_index %0d, expected %0d",
                                                  results_seen, o_entry_index,
                                                  want.entry_index));
                    if (o_already_present !== want.already_present)
                        report_mismatch($sformatf("result %0d: already_present %b, expected %b",
                                                  results_seen, o_already_present,
                                                  want.already_present));
                    if (o_table_full !== want.table_full)
                        report_mismatch($sformatf("result %0d: table_full %b, expected %b",
                                                  results_seen, o_table_full,
                                                  want.table_full));
                end
            end
            if (start && !busy) begin
                expected_results.push_back(predict_intern(i_action, i_value));
            end
            if (i_drain_done && !drain_checked) begin
                drain_checked = 1'b1;
                while (expected_results.size() != 0) begin
                    want = expected_results.pop_front();
                    report_mismatch($sformatf("no result arrived for item (index %0d)",
                                              want.entry_index));
                end
                $display("Summary: %0d results checked: %0d appends, %0d repeats found,",
                         results_seen, n_appends, n_found);
                $display("  %0d full-table refusals, %0d clears, peak occupancy %0d of %0d",
                         n_full, n_clears, peak_count, DEPTH);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// File: tb/tb_dedup_intern_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dedup_intern_table
// Drives insert and clear items into the interning table in random bursts:
// a directed opening, then episodes of well-formed insert runs with repeats,
// including runs that fill the table and keep inserting once it is full.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_dedup_intern_table;
    import dit_pkg::*;

    localparam int DEPTH        = DEF_DEPTH;
    localparam int VALUE_WIDTH  = DEF_VALUE_WIDTH;
    localparam int RANDOM_ITEMS = 1000;
    // Slowest correct run: roughly 1400 items at the longest item time plus the
    // longest sender gap, taken several times over.
    localparam int CYCLE_LIMIT  = 2_000_000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   i_action = ACT_INSERT;
    logic [VALUE_IN_W-1:0]  i_value = '0;
    logic                   o_valid;
    logic [INDEX_OUT_W-1:0] o_entry_index;
    logic                   o_already_present;
    logic                   o_table_full;
    logic                   drain_done = 1'b0;
    int                     err_count;
    int                     pending;
    int                     cycle_count = 0;
    int                     burst_left = 0;
    logic [VALUE_IN_W-1:0]  recent_words [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    dedup_intern_table #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_value           (i_value),
        .o_valid           (o_valid),
        .o_entry_index     (o_entry_index),
        .o_already_present (o_already_present),
        .o_table_full      (o_table_full)
    );

    intern_checker #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_value           (i_value),
        .o_valid           (o_valid),
        .o_entry_index     (o_entry_index),
        .o_already_present (o_already_present),
        .o_table_full      (o_table_full),
        .i_drain_done      (drain_done),
        .o_err_count       (err_count),
        .o_pending         (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    // Start stays high across back-to-back items, so gaps land on any phase.
    task automatic send_item(input logic act, input logic [VALUE_IN_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap   = $urandom_range(1, 8);
            start = 1'b0;
            repeat (gap) begin
                i_action = 1'($urandom);
                i_value  = $urandom;
                @(negedge i_clk);
            end
        end
        burst_left--;
        start    = 1'b1;
        i_action = act;
        i_value  = word;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (act == ACT_CLEAR) recent_words.delete();
        else recent_words.push_back(word);
    endtask

    // Repeats a word of the current run, or picks a corner word or a fresh one.
    function automatic logic [VALUE_IN_W-1:0] pick_word(input int repeat_pct);
        int k;
        int roll;
        k    = $urandom_range(0, VALUE_IN_W - 1);
        roll = $urandom_range(0, 99);
        if (roll < repeat_pct && recent_words.size() != 0)
            return recent_words[$urandom_range(0, recent_words.size() - 1)];
        if (roll >= 92) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return VALUE_IN_W'(1) << k;
                default: return ~(VALUE_IN_W'(1) << k);
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        int  random_items;
        int  ep;
        int  n;
        bit  fill;
        random_items = 0;
        ep           = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed opening: clear on an empty table, extreme words, hits at
        // several depths, and stale store contents after a clear.
        send_item(ACT_CLEAR,  32'h0000_0000);
        send_item(ACT_INSERT, 32'h0000_0000);
        send_item(ACT_INSERT, 32'h0000_0000);
        send_item(ACT_INSERT, 32'hFFFF_FFFF);
        send_item(ACT_INSERT, 32'h8000_0000);
        send_item(ACT_INSERT, 32'h0000_0001);
        send_item(ACT_INSERT, 32'h7FFF_FFFF);
        send_item(ACT_INSERT, 32'hFFFF_FFFF);
        send_item(ACT_INSERT, 32'h0000_0001);
        send_item(ACT_INSERT, 32'hFFFF_FFFE);
        send_item(ACT_CLEAR,  32'hFFFF_FFFF);
        send_item(ACT_INSERT, 32'h7FFF_FFFF);
        send_item(ACT_INSERT, 32'h0000_0000);
        send_item(ACT_INSERT, 32'h7FFF_FFFF);
        send_item(ACT_CLEAR,  32'hA5A5_5A5A);

        // Episodes: usually a clear, then a run of inserts. Fill runs push the
        // table past full so that refusals and hits on a full table occur.
        while (random_items < RANDOM_ITEMS) begin
            fill = (ep == 1) || (ep == 4) || ($urandom_range(0, 11) == 0);
            if (fill || ep == 0 || $urandom_range(0, 4) != 0) begin
                send_item(ACT_CLEAR, $urandom);
                random_items++;
            end
            n = fill ? DEPTH + DEPTH / 4 : $urandom_range(1, 24);
            repeat (n) begin
                if ($urandom_range(0, 39) == 0) send_item(ACT_CLEAR, $urandom);
                else send_item(ACT_INSERT, pick_word(fill ? 8 : 45));
                random_items++;
            end
            if (fill) begin
                repeat ($urandom_range(16, 32)) begin
                    send_item(ACT_INSERT, pick_word(50));
                    random_items++;
                end
            end
            ep++;
        end

        start = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        @(negedge i_clk);
        drain_done = 1'b1;
        repeat (2) @(negedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
